// ===== rtl/rb_pkg.sv =====
// ----------------------------------------------------------------------------
// rb_pkg: shared types and constants of the range and bearing tracker
// Field widths, fixed-point formats, arctangent table and the cell payload.
// ----------------------------------------------------------------------------
package rb_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 24;

  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int BASE_W   = 30;
  localparam int OFF_W    = 32;
  localparam int MAG_W    = 31;
  localparam int BX_W     = 33;
  localparam int ABX_W    = 32;
  localparam int SQ_W     = 64;
  localparam int CX_W     = 64;
  localparam int Z_W      = 36;
  localparam int PRESCALE = 28;

  localparam int PAD_W    = 31;
  localparam int BRANGE_W = 32;
  localparam int BEAR_W   = 19;

  localparam int SQRT_STEPS  = 32;
  localparam int NCELLS      = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int IDX_W       = $clog2(NCELLS);
  localparam int ROUND_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int FRONT_N     = 5;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HOME_LAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_LON  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DIST = 2'd2;

  localparam logic signed [OFF_W-1:0] OFF_LIM     = 32'sd1073741824;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [Z_W-1:0]   PI_Q32      = 36'sd13493037704;

  // atan(2^-i) in 2^-32 rad
  localparam logic signed [Z_W-1:0] ATAN_Q32 [32] = '{
    36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
    36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
    36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
    36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
    36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
    36'sd4096,       36'sd2048,       36'sd1024,       36'sd512,
    36'sd256,        36'sd128,        36'sd64,         36'sd32,
    36'sd16,         36'sd8,          36'sd4,          36'sd2
  };

  typedef struct packed {
    logic [SQ_W-1:0]        pn;
    logic [SQ_W-1:0]        pres;
    logic [SQ_W-1:0]        bn;
    logic [SQ_W-1:0]        bres;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
    logic                   degen;
    logic                   clamped;
  } cell_data_t;

  // trial bit of the square root digit handled by a given cell
  function automatic logic [SQ_W-1:0] sqrt_bit(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] k;
    k = (IDX_W+1)'(SQRT_STEPS - 1) - {1'b0, idx};
    return SQ_W'(1) << {k, 1'b0};
  endfunction

endpackage

// ===== rtl/rb_cell.sv =====
// ----------------------------------------------------------------------------
// rb_cell: one cell of the range and bearing chain
// Does one digit of both square roots and, in the first CORDIC_STAGES cells, one CORDIC vectoring rotation.
// ----------------------------------------------------------------------------
module rb_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rb_pkg::IDX_W-1:0]  idx,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rb_pkg::cell_data_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rb_pkg::cell_data_t        out_data
);
  import rb_pkg::*;

  logic                   valid_r;
  cell_data_t             data_r;
  cell_data_t             data_nxt;
  logic [SQ_W-1:0]        bitv;
  logic [SQ_W-1:0]        ptry;
  logic [SQ_W-1:0]        btry;
  logic signed [CX_W-1:0] cx;
  logic signed [CX_W-1:0] cy;
  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic signed [Z_W-1:0]  cz;
  logic signed [Z_W-1:0]  ang;
  logic                   sqrt_on;
  logic                   cordic_on;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  assign sqrt_on   = {1'b0, idx} < (IDX_W+1)'(SQRT_STEPS);
  assign cordic_on = {1'b0, idx} < (IDX_W+1)'(CORDIC_STAGES);

  always_comb begin
    data_nxt = in_data;
    bitv     = sqrt_bit(idx);
    ptry     = in_data.pres + bitv;
    btry     = in_data.bres + bitv;
    cx       = in_data.x;
    cy       = in_data.y;
    cz       = in_data.z;
    xs       = cx >>> idx;
    ys       = cy >>> idx;
    ang      = ATAN_Q32[idx];
    if (sqrt_on) begin
      if (in_data.pn >= ptry) begin
        data_nxt.pn   = in_data.pn - ptry;
        data_nxt.pres = (in_data.pres >> 1) + bitv;
      end else begin
        data_nxt.pres = in_data.pres >> 1;
      end
      if (in_data.bn >= btry) begin
        data_nxt.bn   = in_data.bn - btry;
        data_nxt.bres = (in_data.bres >> 1) + bitv;
      end else begin
        data_nxt.bres = in_data.bres >> 1;
      end
    end
    if (cordic_on) begin
      if (cy < 0) begin
        data_nxt.x = cx - ys;
        data_nxt.y = cy + xs;
        data_nxt.z = cz - ang;
      end else begin
        data_nxt.x = cx + ys;
        data_nxt.y = cy - xs;
        data_nxt.z = cz + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/rb_front.sv =====
// ----------------------------------------------------------------------------
// rb_front: offset, clamp, fold and square stages
// Forms pad offsets, clamps them, squares the legs and seeds the cell chain.
// ----------------------------------------------------------------------------
module rb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rb_pkg::LAT_W-1:0]   fix_lat,
  input  logic signed [rb_pkg::LON_W-1:0]   fix_lon,
  input  logic signed [rb_pkg::LAT_W-1:0]   home_lat,
  input  logic signed [rb_pkg::LON_W-1:0]   home_lon,
  input  logic [rb_pkg::BASE_W-1:0]         base_dist,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rb_pkg::cell_data_t                out_data
);
  import rb_pkg::*;

  logic [FRONT_N-1:0] v_r;
  logic [FRONT_N:0]   rdy;
  logic [FRONT_N-1:0] ld;

  // stage 0
  logic signed [LAT_W:0]   dlat_full;
  logic signed [LON_W:0]   dlon_full;
  logic signed [OFF_W-1:0] lat0_nxt, lat0_r;
  logic signed [OFF_W-1:0] lon0_nxt, lon0_r;
  logic                    clp0_nxt, clp0_r;
  // stage 1
  logic signed [OFF_W-1:0] alat_w;
  logic signed [OFF_W-1:0] alon_w;
  logic signed [BX_W-1:0]  bx1_nxt, bx1_r;
  logic [MAG_W-1:0]        alat1_r, alon1_r;
  logic                    neg1_r, bz1_r, latz1_r, clp1_r;
  // stage 2
  logic signed [BX_W-1:0]  abx_w;
  logic [ABX_W-1:0]        abx2_r;
  logic [MAG_W-1:0]        alat2_r, alon2_r;
  logic                    bxn2_r, neg2_r, dgn2_r, clp2_r;
  // stage 3
  logic [ABX_W-1:0]        xm, ym;
  logic [2*MAG_W-1:0]      sqlat3_r, sqlon3_r;
  logic [2*ABX_W-1:0]      sqbx3_r;
  logic signed [CX_W-1:0]  x3_r, y3_r;
  logic signed [Z_W-1:0]   z3_r;
  logic                    neg3_r, dgn3_r, clp3_r;
  // stage 4
  cell_data_t              data4_nxt, data4_r;

  always_comb begin
    rdy[FRONT_N] = out_ready;
    for (int k = FRONT_N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < FRONT_N; k++) begin
      ld[k] = rdy[k] && ((k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1]);
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[FRONT_N-1];
  assign out_data  = data4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < FRONT_N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // offsets and clamp
  always_comb begin
    dlat_full = {fix_lat[LAT_W-1], fix_lat} - {home_lat[LAT_W-1], home_lat};
    dlon_full = {fix_lon[LON_W-1], fix_lon} - {home_lon[LON_W-1], home_lon};
    clp0_nxt  = 1'b0;
    lat0_nxt  = OFF_W'(dlat_full);
    lon0_nxt  = OFF_W'(dlon_full);
    if (dlat_full > OFF_LIM) begin
      lat0_nxt = OFF_LIM;
      clp0_nxt = 1'b1;
    end else if (dlat_full < -OFF_LIM) begin
      lat0_nxt = -OFF_LIM;
      clp0_nxt = 1'b1;
    end
    if (dlon_full > OFF_LIM) begin
      lon0_nxt = OFF_LIM;
      clp0_nxt = 1'b1;
    end else if (dlon_full < -OFF_LIM) begin
      lon0_nxt = -OFF_LIM;
      clp0_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lat0_r <= lat0_nxt;
      lon0_r <= lon0_nxt;
      clp0_r <= clp0_nxt;
    end
  end

  // magnitudes and base offset
  always_comb begin
    alat_w  = (lat0_r < 0) ? -lat0_r : lat0_r;
    alon_w  = (lon0_r < 0) ? -lon0_r : lon0_r;
    bx1_nxt = {{(BX_W-BASE_W){1'b0}}, base_dist}
            + {{(BX_W-OFF_W){lon0_r[OFF_W-1]}}, lon0_r};
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      bx1_r   <= bx1_nxt;
      alat1_r <= alat_w[MAG_W-1:0];
      alon1_r <= alon_w[MAG_W-1:0];
      neg1_r  <= (lat0_r <= 0);
      latz1_r <= (lat0_r == 0);
      bz1_r   <= (base_dist == '0);
      clp1_r  <= clp0_r;
    end
  end

  // base leg magnitude and degenerate geometry
  assign abx_w = (bx1_r < 0) ? -bx1_r : bx1_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      abx2_r  <= abx_w[ABX_W-1:0];
      bxn2_r  <= (bx1_r < 0);
      alat2_r <= alat1_r;
      alon2_r <= alon1_r;
      neg2_r  <= neg1_r;
      dgn2_r  <= bz1_r || ((bx1_r == '0) && latz1_r);
      clp2_r  <= clp1_r;
    end
  end

  // squares and quadrant fold
  assign xm = bxn2_r ? {1'b0, alat2_r} : abx2_r;
  assign ym = bxn2_r ? abx2_r : {1'b0, alat2_r};

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sqlat3_r <= alat2_r * alat2_r;
      sqlon3_r <= alon2_r * alon2_r;
      sqbx3_r  <= abx2_r * abx2_r;
      x3_r     <= {{(CX_W-ABX_W-PRESCALE){1'b0}}, xm, {PRESCALE{1'b0}}};
      y3_r     <= {{(CX_W-ABX_W-PRESCALE){1'b0}}, ym, {PRESCALE{1'b0}}};
      z3_r     <= bxn2_r ? HALF_PI_Q32 : '0;
      neg3_r   <= neg2_r;
      dgn3_r   <= dgn2_r;
      clp3_r   <= clp2_r;
    end
  end

  // radicands
  always_comb begin
    data4_nxt.pn      = SQ_W'(sqlat3_r) + SQ_W'(sqlon3_r);
    data4_nxt.bn      = SQ_W'(sqbx3_r) + SQ_W'(sqlat3_r);
    data4_nxt.pres    = '0;
    data4_nxt.bres    = '0;
    data4_nxt.x       = x3_r;
    data4_nxt.y       = y3_r;
    data4_nxt.z       = z3_r;
    data4_nxt.neg     = neg3_r;
    data4_nxt.degen   = dgn3_r;
    data4_nxt.clamped = clp3_r;
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      data4_r <= data4_nxt;
    end
  end

endmodule

// ===== rtl/tracker_range_bearing.sv =====
// ----------------------------------------------------------------------------
// tracker_range_bearing: pad and base range with base pointing angle
// Turns each GPS fix into two horizontal ranges and a bearing angle.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries one fix: fix_lat in bits 30:0, fix_lon in 62:31.
//   out_tdata carries pad_range, base_range and bearing; out_tuser the
//   degenerate and clamped flags. cfg_we writes home_lat (0), home_lon (1)
//   or base_distance (2) from cfg_wdata; other indexes are ignored.
//   Configuration should be written by the user while no item is in flight; the block does not enforce it.
// Pipeline: 5 front stages (offset and clamp, magnitudes, base leg
//   magnitude, squares and fold, radicand sums), a chain of 32 cells each
//   doing one root digit, the first CORDIC_STAGES also one CORDIC rotation,
//   and 2 stages of angle rounding and output register.
// Throughput: one item per cycle while out_tready is high.
// Reset: all stages empty, configuration registers cleared to zero; data registers are not reset.
// Stall: when out_tready is low the output holds; items behind it advance
//   into empty stages, and in_tready drops once every stage is full.
// ----------------------------------------------------------------------------
module tracker_range_bearing (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fix_lat, fix_lon
  input  logic [rb_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pad_range, base_range, bearing
  output logic [rb_pkg::OUT_DATA_W-1:0]     out_tdata,
  // degenerate, clamped
  output logic [rb_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                              cfg_we,
  input  logic [rb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rb_pkg::*;

  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'd1 << (ROUND_SHIFT - 1));

  logic signed [LAT_W-1:0] home_lat_r;
  logic signed [LON_W-1:0] home_lon_r;
  logic [BASE_W-1:0]       base_dist_r;

  cell_data_t chain_d   [NCELLS+1];
  logic       chain_v   [NCELLS+1];
  logic       chain_rdy [NCELLS+1];

  logic                   p0_v_r;
  logic                   p0_rdy;
  logic signed [Z_W-1:0]  zc;
  logic signed [Z_W-1:0]  zs;
  logic signed [Z_W-1:0]  rnd;
  logic [PAD_W-1:0]       p0_pad_r;
  logic [BRANGE_W-1:0]    p0_base_r;
  logic signed [Z_W-1:0]  p0_ang_r;
  logic                   p0_neg_r, p0_dgn_r, p0_clp_r;

  logic                   out_rdy;
  logic                   out_v_r;
  logic signed [Z_W-1:0]  bear_w;
  logic [BEAR_W-1:0]      bear_nxt;
  logic [PAD_W-1:0]       pad_r;
  logic [BRANGE_W-1:0]    base_r;
  logic [BEAR_W-1:0]      bear_r;
  logic                   dgn_r, clp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_lat_r  <= '0;
      home_lon_r  <= '0;
      base_dist_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOME_LAT:  home_lat_r  <= cfg_wdata[LAT_W-1:0];
        REG_HOME_LON:  home_lon_r  <= cfg_wdata[LON_W-1:0];
        REG_BASE_DIST: base_dist_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  rb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .fix_lat   (in_tdata[LAT_W-1:0]),
    .fix_lon   (in_tdata[LAT_W+LON_W-1:LAT_W]),
    .home_lat  (home_lat_r),
    .home_lon  (home_lon_r),
    .base_dist (base_dist_r),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_data  (chain_d[0])
  );

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    rb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(k)),
      .in_valid  (chain_v[k]),
      .in_ready  (chain_rdy[k]),
      .in_data   (chain_d[k]),
      .out_valid (chain_v[k+1]),
      .out_ready (chain_rdy[k+1]),
      .out_data  (chain_d[k+1])
    );
  end

  assign chain_rdy[NCELLS] = p0_rdy;

  // angle saturation and rounding
  assign p0_rdy = !p0_v_r || out_rdy;

  always_comb begin
    zc = chain_d[NCELLS].z;
    if (zc < 0) begin
      zs = '0;
    end else if (zc > PI_Q32) begin
      zs = PI_Q32;
    end else begin
      zs = zc;
    end
    rnd = (zs + ROUND_HALF) >>> ROUND_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (p0_rdy) begin
      p0_v_r <= chain_v[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (p0_rdy && chain_v[NCELLS]) begin
      p0_pad_r  <= chain_d[NCELLS].pres[PAD_W-1:0];
      p0_base_r <= chain_d[NCELLS].bres[BRANGE_W-1:0];
      p0_ang_r  <= rnd;
      p0_neg_r  <= chain_d[NCELLS].neg;
      p0_dgn_r  <= chain_d[NCELLS].degen;
      p0_clp_r  <= chain_d[NCELLS].clamped;
    end
  end

  // sign and output register
  assign out_rdy  = !out_v_r || out_tready;
  assign bear_w   = p0_neg_r ? -p0_ang_r : p0_ang_r;
  assign bear_nxt = p0_dgn_r ? '0 : bear_w[BEAR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= p0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && p0_v_r) begin
      pad_r  <= p0_pad_r;
      base_r <= p0_base_r;
      bear_r <= bear_nxt;
      dgn_r  <= p0_dgn_r;
      clp_r  <= p0_clp_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-PAD_W-BRANGE_W-BEAR_W){1'b0}}, bear_r, base_r, pad_r};
  assign out_tuser  = {clp_r, dgn_r};

endmodule
